>>> sv/joystick_axis_average_percent_core_macros.svh
// Assertion macros shared by the joystick axis averaging RTL.
`ifndef JOYSTICK_AXIS_AVERAGE_PERCENT_CORE_MACROS_SVH
`define JOYSTICK_AXIS_AVERAGE_PERCENT_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JAAP_ASSERT_IMP(name, clk_i, rstn_i, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |-> (post)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define JAAP_ASSERT_NXT(name, clk_i, rstn_i, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/jaap_pkg.sv
// Shared constants for the joystick axis averaging block.
package jaap_pkg;

  localparam int WINDOW_LENGTH_DEF = 8;
  localparam int SAMPLE_BITS_DEF   = 12;

  localparam int PCT_W    = 8;
  localparam int PCT_FULL = 100;
  localparam int PCT_MAX  = 100;
  localparam int PCT_MIN  = -100;

endpackage

>>> sv/joystick_axis_average_percent_core.sv
// An accepted beat passes the window register, then scale stages v2_r to v5_r.
// Throughput: one beat per cycle, set by the sum update, unless out_tready stalls.
// Each of the five pipeline stages advances on its own, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) clears all valid flags, the ring position and
// the primed flag; the history RAM is not cleared, and until the ring wraps once
// the first beat's samples stand in for its unwritten entries.
module joystick_axis_average_percent_core import jaap_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // x_sample, y_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             in_tdata,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // x_filtered, y_filtered, x_percent, y_percent
  output logic [((2*SAMPLE_BITS+2*PCT_W+7)/8)*8-1:0]     out_tdata
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam int OUT_W  = ((2*SAMPLE_BITS+2*PCT_W+7)/8)*8;

  logic                    sum_valid;
  logic                    sum_ready;
  logic [SUM_W-1:0]        x_sum;
  logic [SUM_W-1:0]        y_sum;
  logic [SAMPLE_BITS-1:0]  x_filtered;
  logic [SAMPLE_BITS-1:0]  y_filtered;
  logic signed [PCT_W-1:0] x_percent;
  logic signed [PCT_W-1:0] y_percent;

  jaap_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .x_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .y_sample  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .x_sum     (x_sum),
    .y_sum     (y_sum)
  );

  jaap_scale #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .x_sum      (x_sum),
    .y_sum      (y_sum),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .x_filtered (x_filtered),
    .y_filtered (y_filtered),
    .x_percent  (x_percent),
    .y_percent  (y_percent)
  );

  assign out_tdata = OUT_W'({y_percent, x_percent, y_filtered, x_filtered});

endmodule

>>> sv/jaap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jaap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/jaap_window.sv
// Sample history, shared ring position and running window sums for both axes.
module jaap_window import jaap_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [SAMPLE_BITS-1:0]                         x_sample,
  input  logic [SAMPLE_BITS-1:0]                         y_sample,
  output logic                                           sum_valid,
  input  logic                                           sum_ready,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]   x_sum,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]   y_sum
);

  `include "joystick_axis_average_percent_core_macros.svh"

  localparam int AW    = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = SAMPLE_BITS + AW;
  localparam logic [AW-1:0]    RING_LAST = AW'(WINDOW_LENGTH - 1);
  localparam logic [SUM_W-1:0] SUM_MAX   =
    SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1));

  logic                     valid_r;
  logic                     primed_r;
  logic                     full_r;
  logic [AW-1:0]            ring_r;
  logic [AW-1:0]            ring_nxt;
  logic [SAMPLE_BITS-1:0]   x_first_r;
  logic [SAMPLE_BITS-1:0]   y_first_r;
  logic [SUM_W-1:0]         x_sum_r;
  logic [SUM_W-1:0]         y_sum_r;
  logic [SUM_W-1:0]         x_sum_nxt;
  logic [SUM_W-1:0]         y_sum_nxt;
  logic [SAMPLE_BITS-1:0]   x_old;
  logic [SAMPLE_BITS-1:0]   y_old;
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic                     acc;

  assign in_ready = !valid_r || sum_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    ring_nxt = ring_r;
    if (acc) begin
      ring_nxt = (ring_r == RING_LAST) ? '0 : ring_r + 1'b1;
    end
  end

  // The read address runs one position ahead, so the entry about to be
  // replaced is already in the registered read data when its beat arrives.
  jaap_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (WINDOW_LENGTH)
  ) u_hist (
    .clk   (clk),
    .we    (acc),
    .waddr (ring_r),
    .wdata ({y_sample, x_sample}),
    .raddr (ring_nxt),
    .rdata (rd_data)
  );

  // Until the ring has wrapped once, every replaced entry stands for the first
  // sample, which is kept in a register because those RAM entries were never written.
  assign x_old = full_r ? rd_data[SAMPLE_BITS-1:0] : x_first_r;
  assign y_old = full_r ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : y_first_r;

  always_comb begin
    if (primed_r) begin
      x_sum_nxt = x_sum_r - SUM_W'(x_old) + SUM_W'(x_sample);
      y_sum_nxt = y_sum_r - SUM_W'(y_old) + SUM_W'(y_sample);
    end else begin
      x_sum_nxt = SUM_W'(x_sample) * SUM_W'(WINDOW_LENGTH);
      y_sum_nxt = SUM_W'(y_sample) * SUM_W'(WINDOW_LENGTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      primed_r <= 1'b0;
      full_r   <= 1'b0;
      ring_r   <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (acc) begin
        primed_r <= 1'b1;
        if (primed_r && ring_r == RING_LAST) begin
          full_r <= 1'b1;
        end
      end
      ring_r <= ring_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_sum_r <= x_sum_nxt;
      y_sum_r <= y_sum_nxt;
      if (!primed_r) begin
        x_first_r <= x_sample;
        y_first_r <= y_sample;
      end
    end
  end

  assign sum_valid = valid_r;
  assign x_sum     = x_sum_r;
  assign y_sum     = y_sum_r;

  `JAAP_ASSERT_NXT(a_ring_hold, clk, rst_n, !acc, $stable(ring_r), "Ring moved without a beat.")
  `JAAP_ASSERT_NXT(a_full_set, clk, rst_n, acc && primed_r && ring_r == RING_LAST, full_r, "Wrap missed.")
  `JAAP_ASSERT_IMP(a_sum_range, clk, rst_n, full_r, primed_r && x_sum_r <= SUM_MAX && y_sum_r <= SUM_MAX, "Sum out of range.")

endmodule

>>> sv/jaap_scale.sv
// Pipelined divide-by-window and percentage scaling for both axes.
module jaap_scale import jaap_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         sum_valid,
  output logic                                         sum_ready,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0] x_sum,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0] y_sum,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [SAMPLE_BITS-1:0]                       x_filtered,
  output logic [SAMPLE_BITS-1:0]                       y_filtered,
  output logic signed [PCT_W-1:0]                      x_percent,
  output logic signed [PCT_W-1:0]                      y_percent
);

  `include "joystick_axis_average_percent_core_macros.svh"

  localparam int LANES = 2;
  localparam int S     = SAMPLE_BITS;
  localparam int L1    = $clog2(WINDOW_LENGTH);
  localparam int N1    = S + L1;
  localparam int M1_W  = N1 + 1;
  localparam int P1_W  = N1 + M1_W;
  localparam longint M1_L =
    ((longint'(1) << (N1 + L1)) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
  localparam logic [M1_W-1:0] M1 = M1_W'(M1_L);

  localparam int CENTER = ((1 << SAMPLE_BITS) - 1) / 2;
  localparam int L2     = $clog2(CENTER);
  localparam int N2     = S + 7;
  localparam int M2_W   = N2 + 1;
  localparam int P2_W   = N2 + M2_W;
  localparam longint M2_L =
    ((longint'(1) << (N2 + L2)) + longint'(CENTER) - 1) / longint'(CENTER);
  localparam logic [M2_W-1:0] M2 = M2_W'(M2_L);
  localparam logic [S-1:0]    CENTER_S = S'(CENTER);

  localparam logic        [PCT_W-1:0] PCT_CAP = PCT_W'(PCT_MAX);
  localparam logic signed [PCT_W-1:0] PCT_HI  = PCT_W'(PCT_MAX);
  localparam logic signed [PCT_W-1:0] PCT_LO  = PCT_W'(PCT_MIN);

  logic v2_r, v3_r, v4_r, v5_r;
  logic rdy2, rdy3, rdy4, rdy5;

  logic [N1-1:0]          sum_in   [LANES];
  logic [P1_W-1:0]        prod1_r  [LANES];
  logic [S-1:0]           filt3_nxt[LANES];
  logic                   neg3_nxt [LANES];
  logic [N2-1:0]          mag3_nxt [LANES];
  logic [S-1:0]           filt3_r  [LANES];
  logic                   neg3_r   [LANES];
  logic [N2-1:0]          mag3_r   [LANES];
  logic [S-1:0]           filt4_r  [LANES];
  logic                   neg4_r   [LANES];
  logic [P2_W-1:0]        prod2_r  [LANES];
  logic [PCT_W-1:0]       quo5     [LANES];
  logic [PCT_W-1:0]       cap5     [LANES];
  logic [PCT_W-1:0]       pct5_nxt [LANES];
  logic [S-1:0]           filt5_r  [LANES];
  logic signed [PCT_W-1:0] pct5_r  [LANES];

  assign rdy5      = !v5_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign sum_ready = rdy2;

  assign sum_in[0] = x_sum;
  assign sum_in[1] = y_sum;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      filt3_nxt[l] = prod1_r[l][N1+L1 +: S];
      neg3_nxt[l]  = filt3_nxt[l] < CENTER_S;
      if (neg3_nxt[l]) begin
        mag3_nxt[l] = N2'(CENTER_S - filt3_nxt[l]) * N2'(PCT_FULL);
      end else begin
        mag3_nxt[l] = N2'(filt3_nxt[l] - CENTER_S) * N2'(PCT_FULL);
      end
      quo5[l]     = prod2_r[l][N2+L2 +: PCT_W];
      cap5[l]     = (quo5[l] > PCT_CAP) ? PCT_CAP : quo5[l];
      pct5_nxt[l] = neg4_r[l] ? (~cap5[l] + 1'b1) : cap5[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= sum_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (rdy2) begin
        prod1_r[l] <= P1_W'(sum_in[l]) * P1_W'(M1);
      end
      if (rdy3) begin
        filt3_r[l] <= filt3_nxt[l];
        neg3_r[l]  <= neg3_nxt[l];
        mag3_r[l]  <= mag3_nxt[l];
      end
      if (rdy4) begin
        filt4_r[l] <= filt3_r[l];
        neg4_r[l]  <= neg3_r[l];
        prod2_r[l] <= P2_W'(mag3_r[l]) * P2_W'(M2);
      end
      if (rdy5) begin
        filt5_r[l] <= filt4_r[l];
        pct5_r[l]  <= pct5_nxt[l];
      end
    end
  end

  assign out_valid  = v5_r;
  assign x_filtered = filt5_r[0];
  assign y_filtered = filt5_r[1];
  assign x_percent  = pct5_r[0];
  assign y_percent  = pct5_r[1];

  `JAAP_ASSERT_IMP(a_x_pct_range, clk, rst_n, v5_r, pct5_r[0] <= PCT_HI && pct5_r[0] >= PCT_LO, "X percent out of range.")
  `JAAP_ASSERT_IMP(a_y_pct_range, clk, rst_n, v5_r, pct5_r[1] <= PCT_HI && pct5_r[1] >= PCT_LO, "Y percent out of range.")
  `JAAP_ASSERT_NXT(a_out_drain, clk, rst_n, v5_r && out_ready && !v4_r, !v5_r, "Result repeated.")

endmodule
